>>> sv/token_bucket_rate_limiter_defines.svh
// ----------------------------------------------------------------------------
// Token bucket rate limiter: assertion macros
// Shared property shapes for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef TOKEN_BUCKET_RATE_LIMITER_DEFINES_SVH
`define TOKEN_BUCKET_RATE_LIMITER_DEFINES_SVH

// Same-edge implication, quiet while reset is asserted.
`define TBRL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-edge implication, quiet while reset is asserted.
`define TBRL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// What must hold on the edge after a reset edge.
`define TBRL_ASSERT_RST(label, cons, msg) \
    label: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) else $error(msg);

`endif

>>> sv/tbrl_pkg.sv
// ----------------------------------------------------------------------------
// tbrl_pkg
// Widths, register indices, reset values and helpers for the rate limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package tbrl_pkg;

    localparam int NUM_BUCKETS = 8;
    localparam int IDX_W       = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

    localparam int NOW_W    = 48;
    localparam int CAT_W    = 3;
    localparam int TOK_W    = 18;
    localparam int EL_W     = 18;
    localparam int BYTE_W   = 8;
    localparam int LIM_W    = 16;
    localparam int PROD_W   = EL_W + BYTE_W;
    localparam int SUM_W    = PROD_W + 1;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = CAT_W;
    localparam int M_TDATA_W = 24;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = LIM_W;

    localparam logic [TOK_W-1:0] MILLI = TOK_W'(1000);

    localparam logic [CFG_ADDR_W-1:0] REG_LIMITS_MESSAGE  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMITS_REACTION = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMITS_TYPING   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMITS_PRESENCE = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMITS_FALLBACK = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_WARN_PERIOD     = 3'd5;

    localparam logic [CAT_W-1:0] CAT_MESSAGE  = 3'd0;
    localparam logic [CAT_W-1:0] CAT_REACTION = 3'd1;
    localparam logic [CAT_W-1:0] CAT_TYPING   = 3'd2;
    localparam logic [CAT_W-1:0] CAT_PRESENCE = 3'd3;

    localparam logic [LIM_W-1:0]  RST_LIMITS_MESSAGE  = 16'h0A05;
    localparam logic [LIM_W-1:0]  RST_LIMITS_REACTION = 16'h1008;
    localparam logic [LIM_W-1:0]  RST_LIMITS_TYPING   = 16'h0804;
    localparam logic [LIM_W-1:0]  RST_LIMITS_PRESENCE = 16'h0301;
    localparam logic [LIM_W-1:0]  RST_LIMITS_FALLBACK = 16'h140A;
    localparam logic [BYTE_W-1:0] RST_WARN_PERIOD     = 8'd20;

    typedef struct packed {
        logic [LIM_W-1:0]  limits_message;
        logic [LIM_W-1:0]  limits_reaction;
        logic [LIM_W-1:0]  limits_typing;
        logic [LIM_W-1:0]  limits_presence;
        logic [LIM_W-1:0]  limits_fallback;
        logic [BYTE_W-1:0] warn_period;
    } t_cfg_regs;

    typedef struct packed {
        logic [NOW_W-1:0] stamp;
        logic [TOK_W-1:0] tokens;
    } t_bucket;

    function automatic logic [LIM_W-1:0] limits_of(input t_cfg_regs cfg,
                                                   input logic [CAT_W-1:0] cat);
        logic [LIM_W-1:0] lim;
        unique case (cat)
            CAT_MESSAGE:  lim = cfg.limits_message;
            CAT_REACTION: lim = cfg.limits_reaction;
            CAT_TYPING:   lim = cfg.limits_typing;
            CAT_PRESENCE: lim = cfg.limits_presence;
            default:      lim = cfg.limits_fallback;
        endcase
        return lim;
    endfunction

    // Categories past the last bucket share the last bucket.
    function automatic logic [IDX_W-1:0] bucket_index(input logic [CAT_W-1:0] cat);
        logic [IDX_W-1:0] idx;
        if (int'(cat) < NUM_BUCKETS) begin
            idx = IDX_W'(cat);
        end else begin
            idx = IDX_W'(NUM_BUCKETS - 1);
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

>>> sv/tbrl_cfg_regs.sv
// ----------------------------------------------------------------------------
// tbrl_cfg_regs
// Write-only register file for bucket limits and the warning period.
// ----------------------------------------------------------------------------
`default_nettype none

module tbrl_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tbrl_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [tbrl_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output tbrl_pkg::t_cfg_regs                o_cfg
);
    import tbrl_pkg::*;

    t_cfg_regs r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.limits_message  <= RST_LIMITS_MESSAGE;
            r_cfg.limits_reaction <= RST_LIMITS_REACTION;
            r_cfg.limits_typing   <= RST_LIMITS_TYPING;
            r_cfg.limits_presence <= RST_LIMITS_PRESENCE;
            r_cfg.limits_fallback <= RST_LIMITS_FALLBACK;
            r_cfg.warn_period     <= RST_WARN_PERIOD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_LIMITS_MESSAGE:  r_cfg.limits_message  <= i_cfg_wdata;
                REG_LIMITS_REACTION: r_cfg.limits_reaction <= i_cfg_wdata;
                REG_LIMITS_TYPING:   r_cfg.limits_typing   <= i_cfg_wdata;
                REG_LIMITS_PRESENCE: r_cfg.limits_presence <= i_cfg_wdata;
                REG_LIMITS_FALLBACK: r_cfg.limits_fallback <= i_cfg_wdata;
                REG_WARN_PERIOD:     r_cfg.warn_period     <= i_cfg_wdata[BYTE_W-1:0];
                default: ; // drop writes past the register list
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> sv/token_bucket_rate_limiter.sv
// ----------------------------------------------------------------------------
// token_bucket_rate_limiter
// Per-category token bucket limiter with a shared throttle-notice counter.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave channel: one request per event; tdata carries the 48-bit ms
//    timestamp, tuser the 3-bit category. Master channel: one result per
//    request (allowed, notify, tokens left in thousandths).
//  - Bucket state (tokens and last refill time) lives in a synchronous
//    memory whose read is registered on acceptance. Each request walks
//    read -> elapsed/cap -> multiply -> add/clamp -> spend and write back.
//  - The result is registered when the spend stage (DONE) releases it,
//    after the READ, MUL and ADD states. The read-modify-write sequence
//    on the bucket memory holds the slave channel until write-back.
//  - Stalls: the result register holds while tready is low; a finished
//    request waits in the spend stage, and the next request is taken only
//    after its result has been stored.
//  - Reset (synchronous, active low): clears all bucket valid bits, the
//    denial phase and the output register, and restores the limit
//    registers. A bucket is filled to burst on first use, so no memory
//    clearing pass is needed.
//  - Configuration writes are taken at any cycle, but change limits only
//    safely while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module token_bucket_rate_limiter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Slave request channel
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [tbrl_pkg::S_TDATA_W-1:0]    i_s_tdata,  // [47:0] now_ms, [55:48] zero
    input  logic [tbrl_pkg::S_TUSER_W-1:0]    i_s_tuser,  // [2:0] category
    // Master result channel
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [tbrl_pkg::M_TDATA_W-1:0]    o_m_tdata,  // [0] allowed, [1] notify,
                                                          // [19:2] tokens_left, [23:20] zero
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [tbrl_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [tbrl_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import tbrl_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } t_state;

    t_cfg_regs cfg;

    t_state              r_state;
    logic [NOW_W-1:0]    r_now;
    logic [IDX_W-1:0]    r_idx;
    logic [BYTE_W-1:0]   r_burst;
    logic [BYTE_W-1:0]   r_rate;
    logic                r_first;
    logic [TOK_W-1:0]    r_cap;
    logic [EL_W-1:0]     r_el;
    logic                r_refill;
    logic [PROD_W-1:0]   r_prod;
    logic [TOK_W-1:0]    r_tok;
    logic [NOW_W-1:0]    r_stamp;
    logic [BYTE_W-1:0]   r_phase;
    logic [NUM_BUCKETS-1:0] r_valid;
    logic                r_out_valid;
    logic                r_out_allowed;
    logic                r_out_notify;
    logic [TOK_W-1:0]    r_out_tokens;

    // Bucket store: one word per bucket, registered read.
    t_bucket r_mem [NUM_BUCKETS];
    t_bucket r_rd;

    logic              accept;
    logic              done_fire;
    logic [IDX_W-1:0]  n_idx;
    logic [LIM_W-1:0]  n_lim;
    logic [NOW_W-1:0]  n_diff;
    logic [EL_W-1:0]   n_el;
    logic [TOK_W-1:0]  n_cap;
    logic [SUM_W-1:0]  n_sum;
    logic [TOK_W-1:0]  n_tok;
    logic [NOW_W-1:0]  n_stamp;
    logic              n_allowed;
    logic [TOK_W-1:0]  n_tok_out;
    logic [BYTE_W:0]   n_phase_inc;
    logic [BYTE_W:0]   n_period;
    logic [BYTE_W-1:0] n_phase;

    tbrl_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    // Leave the spend stage only when the result register is free.
    assign done_fire  = (r_state == ST_DONE) && (!r_out_valid || i_m_tready);

    assign n_idx = bucket_index(i_s_tuser);
    assign n_lim = limits_of(cfg, i_s_tuser);

    // Elapsed time, saturated to the refill window.
    assign n_diff = r_now - r_rd.stamp;
    assign n_el   = (|n_diff[NOW_W-1:EL_W]) ? {EL_W{1'b1}} : n_diff[EL_W-1:0];
    assign n_cap  = TOK_W'(r_burst) * MILLI;

    // Refill and clamp at burst once time has moved on; a fresh bucket starts full.
    always_comb begin
        n_sum = SUM_W'(r_rd.tokens) + SUM_W'(r_prod);
        if (r_first) begin
            n_tok   = r_cap;
            n_stamp = r_now;
        end else if (r_refill) begin
            n_tok   = (n_sum < SUM_W'(r_cap)) ? n_sum[TOK_W-1:0] : r_cap;
            n_stamp = r_now;
        end else begin
            n_tok   = r_rd.tokens;
            n_stamp = r_rd.stamp;
        end
    end

    // Spend a token or count a denial; a zero period wraps at 256.
    always_comb begin
        n_allowed   = (r_tok >= MILLI);
        n_tok_out   = n_allowed ? (r_tok - MILLI) : r_tok;
        n_phase_inc = {1'b0, r_phase} + (BYTE_W+1)'(1);
        n_period    = (cfg.warn_period == '0) ? (BYTE_W+1)'(1 << BYTE_W)
                                              : {1'b0, cfg.warn_period};
        n_phase     = (n_phase_inc >= n_period) ? '0 : n_phase_inc[BYTE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (done_fire) begin
            r_mem[r_idx] <= '{stamp: r_stamp, tokens: n_tok_out};
        end
        if (accept) begin
            r_rd <= r_mem[n_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Load a finished request, else release a taken result.
            if (done_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_m_tvalid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_now   <= i_s_tdata[NOW_W-1:0];
                        r_idx   <= n_idx;
                        r_burst <= n_lim[LIM_W-1:BYTE_W];
                        r_rate  <= n_lim[BYTE_W-1:0];
                        r_first <= !r_valid[n_idx];
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_el     <= n_el;
                    r_refill <= (r_now > r_rd.stamp);
                    r_cap    <= n_cap;
                    r_state  <= ST_MUL;
                end
                ST_MUL: begin
                    r_prod  <= PROD_W'(r_el) * PROD_W'(r_rate);
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    r_tok   <= n_tok;
                    r_stamp <= n_stamp;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (done_fire) begin
                        r_valid[r_idx] <= 1'b1;
                        if (!n_allowed) begin
                            r_phase <= n_phase;
                        end
                        r_out_allowed <= n_allowed;
                        r_out_notify  <= !n_allowed && (r_phase == '0);
                        r_out_tokens  <= n_tok_out;
                        r_state       <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W-TOK_W-2){1'b0}}, r_out_tokens, r_out_notify, r_out_allowed};

endmodule

`default_nettype wire

>>> sv/tbrl_checker.sv
// ----------------------------------------------------------------------------
// tbrl_checker
// Port-level checks on the rate limiter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "token_bucket_rate_limiter_defines.svh"

module tbrl_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              o_s_tready,
    input  logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    input  logic [tbrl_pkg::M_TDATA_W-1:0]    o_m_tdata   // [0] allowed, [1] notify,
                                                          // [19:2] tokens_left
);
    import tbrl_pkg::*;

    // A notice only ever comes with a denial.
    `TBRL_ASSERT_IMP(a_notify_on_denial, o_m_tvalid, !(o_m_tdata[0] && o_m_tdata[1]), "notify with allowed")

    // Tokens never exceed the largest possible burst.
    `TBRL_ASSERT_IMP(a_tokens_bound, o_m_tvalid, o_m_tdata[19:2] <= 18'd255000, "tokens above burst limit")

    // One request at a time: the slave side closes after each acceptance.
    `TBRL_ASSERT_NXT(a_one_in_flight, i_s_tvalid && o_s_tready, !o_s_tready, "second request taken while busy")

    // A stalled result holds.
    `TBRL_ASSERT_NXT(a_result_holds, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "stalled result changed")

    // Reset leaves an empty output and an open slave side.
    `TBRL_ASSERT_RST(a_reset_state, !o_m_tvalid && o_s_tready, "bad state after reset")

endmodule

bind token_bucket_rate_limiter tbrl_checker u_tbrl_checker (.*);

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the token bucket rate limiter. A short table of
// hand-picked requests comes first: first use, time standing still or
// running backward, zero and full limits, lowered caps, notice periods and
// ignored register writes. Then several phases of random requests run, each
// under fresh limit settings. Every result is checked against an in-bench
// model of the buckets and the shared denial counter.
// ----------------------------------------------------------------------------
module tb_top;
    import tbrl_pkg::*;

    localparam int     HALF_PERIOD    = 4;
    localparam int     RESET_CYCLES   = 8;
    localparam int     LATENCY        = 4;
    localparam int     PHASES         = 9;
    localparam int     PHASE_REQUESTS = 150;
    localparam int     MAX_IDLE       = 16;
    localparam longint RUN_LIMIT_NS   = 5_000_000;

    localparam logic [NOW_W-1:0] ELAPSED_CAP = NOW_W'(262143);
    localparam logic [31:0]      TOKEN_COST  = 32'(MILLI);
    localparam logic [NOW_W-1:0] STAMP_TOP   = {NOW_W{1'b1}};

    // Register indexes past the end of the map; writes to them must vanish.
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

    // Categories without a name of their own; they all take the fallback limits.
    localparam logic [CAT_W-1:0] CAT_OTHER_4 = 3'd4;
    localparam logic [CAT_W-1:0] CAT_OTHER_5 = 3'd5;
    localparam logic [CAT_W-1:0] CAT_OTHER_6 = 3'd6;
    localparam logic [CAT_W-1:0] CAT_OTHER_7 = 3'd7;

    typedef struct packed {
        logic             allowed;
        logic             notify;
        logic [TOK_W-1:0] tokens;
    } t_verdict;

    typedef enum logic {ROW_EVENT, ROW_WRITE} t_row_kind;

    // One line of the opening table: a request (sel is the category) or a
    // register write (sel is the register index). Typed verdicts are used as
    // given; all other rows are checked against the model.
    typedef struct packed {
        t_row_kind         kind;
        logic [NOW_W-1:0]  now;
        logic [CAT_W-1:0]  sel;
        logic [LIM_W-1:0]  wdata;
        logic              typed;
        t_verdict          verdict;
    } t_plan_row;

    localparam t_verdict NO_VERDICT = '0;
    localparam int       PLAN_ROWS  = 35;

    localparam t_plan_row OPENING_PLAN [PLAN_ROWS] = '{
        // first use fills to burst, then spends one token
        '{ROW_EVENT, 48'd0, CAT_MESSAGE, 16'd0, 1'b1, '{1'b1, 1'b0, 18'd9000}},
        // drain the presence bucket at a standing clock
        '{ROW_EVENT, 48'd0, CAT_PRESENCE, 16'd0, 1'b1, '{1'b1, 1'b0, 18'd2000}},
        '{ROW_EVENT, 48'd0, CAT_PRESENCE, 16'd0, 1'b1, '{1'b1, 1'b0, 18'd1000}},
        '{ROW_EVENT, 48'd0, CAT_PRESENCE, 16'd0, 1'b1, '{1'b1, 1'b0, 18'd0}},
        // the very first denial raises a notice
        '{ROW_EVENT, 48'd0, CAT_PRESENCE, 16'd0, 1'b1, '{1'b0, 1'b1, 18'd0}},
        // partial refill, then time running backward, then a whole token
        '{ROW_EVENT, 48'd999, CAT_PRESENCE, 16'd0, 1'b0, NO_VERDICT},
        '{ROW_EVENT, 48'd500, CAT_PRESENCE, 16'd0, 1'b0, NO_VERDICT},
        '{ROW_EVENT, 48'd1000, CAT_PRESENCE, 16'd0, 1'b0, NO_VERDICT},
        // timestamp extremes
        '{ROW_EVENT, STAMP_TOP, CAT_REACTION, 16'd0, 1'b1, '{1'b1, 1'b0, 18'd15000}},
        '{ROW_EVENT, 48'd0, CAT_REACTION, 16'd0, 1'b0, NO_VERDICT},
        '{ROW_EVENT, 48'h8000_0000_0000, CAT_TYPING, 16'd0, 1'b1,
          '{1'b1, 1'b0, 18'd7000}},
        '{ROW_EVENT, 48'd5, CAT_OTHER_4, 16'd0, 1'b1, '{1'b1, 1'b0, 18'd19000}},
        '{ROW_EVENT, 48'd6, CAT_OTHER_5, 16'd0, 1'b1, '{1'b1, 1'b0, 18'd19000}},
        // zero burst and rate: a fresh bucket denies, a used one is cut to zero
        '{ROW_WRITE, 48'd0, REG_LIMITS_FALLBACK, 16'h0000, 1'b0, NO_VERDICT},
        '{ROW_EVENT, 48'd7, CAT_OTHER_7, 16'd0, 1'b0, NO_VERDICT},
        '{ROW_EVENT, 48'd100000, CAT_OTHER_6, 16'd0, 1'b0, NO_VERDICT},
        '{ROW_EVENT, 48'd100000, CAT_OTHER_4, 16'd0, 1'b0, NO_VERDICT},
        // lowered cap: tokens above it survive until the next refill
        '{ROW_WRITE, 48'd0, REG_LIMITS_MESSAGE, 16'h0205, 1'b0, NO_VERDICT},
        '{ROW_EVENT, 48'd0, CAT_MESSAGE, 16'd0, 1'b0, NO_VERDICT},
        '{ROW_EVENT, 48'd1, CAT_MESSAGE, 16'd0, 1'b0, NO_VERDICT},
        // notice period of zero counts as 256
        '{ROW_WRITE, 48'd0, REG_WARN_PERIOD, 16'h0000, 1'b0, NO_VERDICT},
        '{ROW_EVENT, 48'd1, CAT_OTHER_7, 16'd0, 1'b0, NO_VERDICT},
        // period lowered below the running count: next denial wraps it
        '{ROW_WRITE, 48'd0, REG_WARN_PERIOD, 16'h0001, 1'b0, NO_VERDICT},
        '{ROW_EVENT, 48'd2, CAT_OTHER_7, 16'd0, 1'b0, NO_VERDICT},
        '{ROW_EVENT, 48'd3, CAT_OTHER_7, 16'd0, 1'b0, NO_VERDICT},
        // full limits, zero rate, and writes to indexes past the map
        '{ROW_WRITE, 48'd0, REG_LIMITS_PRESENCE, 16'hFFFF, 1'b0, NO_VERDICT},
        '{ROW_WRITE, 48'd0, REG_LIMITS_REACTION, 16'hFFFF, 1'b0, NO_VERDICT},
        '{ROW_WRITE, 48'd0, REG_LIMITS_TYPING, 16'hFF00, 1'b0, NO_VERDICT},
        '{ROW_WRITE, 48'd0, REG_SPARE_LO, 16'hFFFF, 1'b0, NO_VERDICT},
        '{ROW_WRITE, 48'd0, REG_SPARE_HI, 16'h1234, 1'b0, NO_VERDICT},
        // saturated elapsed time, refill capped at the largest burst
        '{ROW_EVENT, STAMP_TOP, CAT_PRESENCE, 16'd0, 1'b1, '{1'b1, 1'b0, 18'd254000}},
        '{ROW_EVENT, STAMP_TOP, CAT_REACTION, 16'd0, 1'b0, NO_VERDICT},
        '{ROW_EVENT, STAMP_TOP, CAT_TYPING, 16'd0, 1'b0, NO_VERDICT},
        '{ROW_WRITE, 48'd0, REG_WARN_PERIOD, 16'h00FF, 1'b0, NO_VERDICT},
        '{ROW_EVENT, 48'h7FFF_FFFF_FFFF, CAT_OTHER_7, 16'd0, 1'b0, NO_VERDICT}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata;   // [47:0] now_ms, [55:48] zero
    logic [S_TUSER_W-1:0]  i_s_tuser;   // [2:0] category
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [M_TDATA_W-1:0]  o_m_tdata;   // [0] allowed, [1] notify, [19:2] tokens_left,
                                        // [23:20] zero
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    // Model of the block: limit registers, buckets and the denial counter.
    logic [LIM_W-1:0]       lim_mirror [0:int'(REG_LIMITS_FALLBACK)];
    logic [BYTE_W-1:0]      notice_period;
    logic [NUM_BUCKETS-1:0] bkt_live;
    logic [31:0]            bkt_level [NUM_BUCKETS];
    logic [NOW_W-1:0]       bkt_stamp [NUM_BUCKETS];
    logic [BYTE_W-1:0]      denial_count;

    t_verdict         pending_verdicts [$];
    logic [NOW_W-1:0] clock_ms;
    logic             sender_quiet;
    logic             receiver_quiet;
    int               mismatches;
    int               requests_sent;
    int               reg_writes;
    int               grants;
    int               refusals;
    int               notices;

    token_bucket_rate_limiter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    // Refill, cap and spend for one request; advance the shared denial count.
    function automatic t_verdict judge_event(input logic [NOW_W-1:0] now,
                                             input logic [CAT_W-1:0] cat);
        logic [LIM_W-1:0] lim;
        logic [31:0]      cap;
        logic [31:0]      level;
        logic [NOW_W-1:0] gap_ms;
        logic [8:0]       period;
        logic [8:0]       next_count;
        int               slot;
        t_verdict         v;
        case (cat)
            CAT_MESSAGE:  lim = lim_mirror[REG_LIMITS_MESSAGE];
            CAT_REACTION: lim = lim_mirror[REG_LIMITS_REACTION];
            CAT_TYPING:   lim = lim_mirror[REG_LIMITS_TYPING];
            CAT_PRESENCE: lim = lim_mirror[REG_LIMITS_PRESENCE];
            default:      lim = lim_mirror[REG_LIMITS_FALLBACK];
        endcase
        cap  = 32'(lim[LIM_W-1:BYTE_W]) * TOKEN_COST;
        slot = (int'(cat) < NUM_BUCKETS) ? int'(cat) : NUM_BUCKETS - 1;
        if (!bkt_live[slot]) begin
            bkt_live[slot]  = 1'b1;
            bkt_level[slot] = cap;
            bkt_stamp[slot] = now;
        end else if (now > bkt_stamp[slot]) begin
            gap_ms = now - bkt_stamp[slot];
            if (gap_ms > ELAPSED_CAP) begin
                gap_ms = ELAPSED_CAP;
            end
            level           = bkt_level[slot] + 32'(gap_ms) * 32'(lim[BYTE_W-1:0]);
            bkt_level[slot] = (level < cap) ? level : cap;
            bkt_stamp[slot] = now;
        end
        v     = '0;
        level = bkt_level[slot];
        if (level >= TOKEN_COST) begin
            bkt_level[slot] = level - TOKEN_COST;
            v.allowed       = 1'b1;
        end else begin
            period       = (notice_period == '0) ? 9'd256 : {1'b0, notice_period};
            v.notify     = (denial_count == '0);
            next_count   = {1'b0, denial_count} + 9'd1;
            denial_count = (next_count >= period) ? '0 : next_count[BYTE_W-1:0];
        end
        v.tokens = bkt_level[slot][TOK_W-1:0];
        return v;
    endfunction

    // Mostly a clock creeping forward; now and then a step back, a jump to a
    // random stamp anywhere in the 48-bit range, or a stamp near the top.
    function automatic logic [NOW_W-1:0] next_stamp();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            clock_ms = NOW_W'({$urandom(), $urandom()});
        end else if (pick < 6) begin
            clock_ms = clock_ms - NOW_W'($urandom_range(0, 2000));
        end else if (pick < 8) begin
            clock_ms = STAMP_TOP - NOW_W'($urandom_range(0, 1000));
        end else if (pick < 48) begin
            clock_ms = clock_ms + NOW_W'($urandom_range(0, 20));
        end else if (pick < 88) begin
            clock_ms = clock_ms + NOW_W'($urandom_range(0, 400));
        end else begin
            clock_ms = clock_ms + NOW_W'($urandom_range(0, 5000));
        end
        return clock_ms;
    endfunction

    // Small bursts and rates keep denials common; the first two phases pin
    // every limit to its extremes.
    function automatic logic [LIM_W-1:0] pick_limits(input int phase);
        if (phase == 0) return '1;
        if (phase == 1) return '0;
        if ($urandom_range(0, 9) == 0) return LIM_W'($urandom());
        return {BYTE_W'($urandom_range(0, 12)), BYTE_W'($urandom_range(0, 40))};
    endfunction

    function automatic logic [LIM_W-1:0] pick_period(input int phase);
        if (phase == 0) return LIM_W'(8'd255);
        if (phase == 1) return '0;
        if (phase == 2) return LIM_W'(8'd1);
        if ($urandom_range(0, 9) == 0) return LIM_W'($urandom_range(0, 255));
        return LIM_W'($urandom_range(1, 8));
    endfunction

    // Call at a falling edge while idle; hold the write for one edge.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        if (addr == REG_WARN_PERIOD) begin
            notice_period = data[BYTE_W-1:0];
        end else if (addr <= REG_LIMITS_FALLBACK) begin
            lim_mirror[addr] = data;
        end
        reg_writes++;
    endtask

    // Call at a falling edge; returns at the falling edge after acceptance
    // with tvalid still high, so a back-to-back request needs no second
    // assignment in the same step.
    task automatic push_event(input logic [NOW_W-1:0] now, input logic [CAT_W-1:0] cat,
                              input logic typed, input t_verdict typed_verdict);
        int unsigned gap;
        t_verdict    predicted;
        gap = sender_quiet ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= S_TDATA_W'(now);
        i_s_tuser  <= cat;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predicted = judge_event(now, cat);
        pending_verdicts = {pending_verdicts, (typed ? typed_verdict : predicted)};
        requests_sent++;
        @(negedge i_clk);
    endtask

    // Drop the request line and wait for every outstanding result.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("token_bucket_rate_limiter verification failed");
        $finish;
    end

    // Result side: stall at random, then take one result and check it.
    initial begin : result_sink
        int unsigned stall;
        t_verdict    want;
        t_verdict    got;
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = receiver_quiet ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall != 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
            got.allowed = o_m_tdata[0];
            got.notify  = o_m_tdata[1];
            got.tokens  = o_m_tdata[2 +: TOK_W];
            if (pending_verdicts.size() == 0) begin
                $error("result with no request outstanding: tdata %h", o_m_tdata);
                mismatches++;
            end else begin
                want = pending_verdicts.pop_front();
                if (got.allowed !== want.allowed) begin
                    $error("allowed: expected %0d, got %0d", want.allowed, got.allowed);
                    mismatches++;
                end
                if (got.notify !== want.notify) begin
                    $error("notify: expected %0d, got %0d", want.notify, got.notify);
                    mismatches++;
                end
                if (got.tokens !== want.tokens) begin
                    $error("tokens_left: expected %0d, got %0d", want.tokens, got.tokens);
                    mismatches++;
                end
            end
            if (got.allowed === 1'b1) grants++;
            else refusals++;
            if (got.notify === 1'b1) notices++;
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = '0;
        i_cfg_we       = 1'b0;
        i_cfg_addr     = '0;
        i_cfg_wdata    = '0;
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b0;
        clock_ms       = '0;
        mismatches     = 0;
        requests_sent  = 0;
        reg_writes     = 0;
        grants         = 0;
        refusals       = 0;
        notices        = 0;
        lim_mirror[REG_LIMITS_MESSAGE]  = RST_LIMITS_MESSAGE;
        lim_mirror[REG_LIMITS_REACTION] = RST_LIMITS_REACTION;
        lim_mirror[REG_LIMITS_TYPING]   = RST_LIMITS_TYPING;
        lim_mirror[REG_LIMITS_PRESENCE] = RST_LIMITS_PRESENCE;
        lim_mirror[REG_LIMITS_FALLBACK] = RST_LIMITS_FALLBACK;
        notice_period = RST_WARN_PERIOD;
        bkt_live      = '0;
        denial_count  = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Opening table; registers change only once every result is home.
        for (int i = 0; i < PLAN_ROWS; i++) begin
            if (OPENING_PLAN[i].kind == ROW_WRITE) begin
                drain();
                write_reg(OPENING_PLAN[i].sel, OPENING_PLAN[i].wdata);
            end else begin
                push_event(OPENING_PLAN[i].now, OPENING_PLAN[i].sel,
                           OPENING_PLAN[i].typed, OPENING_PLAN[i].verdict);
            end
        end

        // Random phases, each with fresh limits and its own idling pattern.
        for (int p = 0; p < PHASES; p++) begin
            drain();
            sender_quiet   = (p % 3 == 1);
            receiver_quiet = (p % 4 == 2);
            for (int r = int'(REG_LIMITS_MESSAGE); r <= int'(REG_LIMITS_FALLBACK); r++) begin
                write_reg(CFG_ADDR_W'(r), pick_limits(p));
            end
            write_reg(REG_WARN_PERIOD, pick_period(p));
            if ($urandom_range(0, 2) == 0) begin
                write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_LO : REG_SPARE_HI,
                          LIM_W'($urandom()));
            end
            repeat (PHASE_REQUESTS) begin
                push_event(next_stamp(), CAT_W'($urandom_range(0, 7)), 1'b0, NO_VERDICT);
            end
        end
        drain();

        $display("Ran %0d requests across %0d register writes: %0d allowed, %0d refused,",
                 requests_sent, reg_writes, grants, refusals);
        $display("%0d throttle notices raised, %0d field mismatches", notices, mismatches);
        if (mismatches == 0) begin
            $display("token_bucket_rate_limiter verification clean");
        end else begin
            $display("token_bucket_rate_limiter verification failed");
        end
        $finish;
    end

endmodule
